// ===== rtl/ytlp_pkg.sv =====
// Shared constants, types and helper functions for the YUYV thick line plotter.
package ytlp_pkg;

    // Largest dot side that still draws.
    localparam logic [3:0] MAX_DOT = 4'd10;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DOT_SIZE     = 3'd2;
    localparam logic [2:0] REG_LUMA         = 3'd3;
    localparam logic [2:0] REG_CHROMA_U     = 3'd4;
    localparam logic [2:0] REG_CHROMA_V     = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [3:0]  RST_DOT_SIZE     = 4'd1;
    localparam logic [7:0]  RST_LUMA         = 8'd0;
    localparam logic [7:0]  RST_CHROMA       = 8'd128;

    // One dot pixel leaving the walker, before clipping and addressing.
    typedef struct packed {
        logic               valid;
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic               last;
    } ytlp_pixel_t;

    // Clamp a 12-bit coordinate to dim-1 (to zero for an empty dimension).
    function automatic logic [12:0] clamp_coord(input logic [11:0] c, input logic [12:0] dim);
        logic [12:0] lim;
        logic [12:0] cw;
        lim = (dim == 13'd0) ? 13'd0 : dim - 13'd1;
        cw  = {1'b0, c};
        return (cw > lim) ? lim : cw;
    endfunction

    // Absolute difference of two unsigned coordinates.
    function automatic logic [12:0] abs_diff(input logic [12:0] a, input logic [12:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

// ===== rtl/ytlp_walk.sv =====
// Bresenham walk state and dot scan, producing one unclipped pixel per advance beat while a line is active.
module ytlp_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_accept,
    input  logic                 op,
    input  logic [11:0]          x_start,
    input  logic [11:0]          y_start,
    input  logic [11:0]          x_end,
    input  logic [11:0]          y_end,
    input  logic [12:0]          frame_width,
    input  logic [12:0]          frame_height,
    input  logic [3:0]           dot_size,
    output ytlp_pkg::ytlp_pixel_t pix
);

    logic               busy_reg;
    logic [12:0]        major_pos_reg;
    logic [12:0]        minor_pos_reg;
    logic [12:0]        major_last_reg;
    logic signed [13:0] walk_error_reg;
    logic [12:0]        delta_major_reg;
    logic [12:0]        delta_minor_reg;
    logic               is_steep_reg;
    logic               minor_dec_reg;
    logic [3:0]         dot_col_reg;
    logic [3:0]         dot_row_reg;

    logic               size_ok;
    logic [12:0]        x0, y0, x1, y1;
    logic               steep;
    logic [12:0]        ra0, ra1, rb0, rb1;
    logic               swap;
    logic [12:0]        a0, a1, b0, b1;

    logic               col_end, row_end, at_last;
    logic signed [13:0] err_sub, err_fix;
    logic [12:0]        cx, cy;

    assign size_ok = (dot_size != 4'd0) && (dot_size <= ytlp_pkg::MAX_DOT);

    // Line setup: clamp endpoints, pick the major axis, order by major coordinate.
    always_comb begin
        x0    = ytlp_pkg::clamp_coord(x_start, frame_width);
        y0    = ytlp_pkg::clamp_coord(y_start, frame_height);
        x1    = ytlp_pkg::clamp_coord(x_end, frame_width);
        y1    = ytlp_pkg::clamp_coord(y_end, frame_height);
        steep = ytlp_pkg::abs_diff(y1, y0) > ytlp_pkg::abs_diff(x1, x0);
        ra0   = steep ? y0 : x0;
        rb0   = steep ? x0 : y0;
        ra1   = steep ? y1 : x1;
        rb1   = steep ? x1 : y1;
        swap  = ra0 > ra1;
        a0    = swap ? ra1 : ra0;
        a1    = swap ? ra0 : ra1;
        b0    = swap ? rb1 : rb0;
        b1    = swap ? rb0 : rb1;
    end

    // Dot scan position and the next walk error.
    always_comb begin
        col_end = ({1'b0, dot_col_reg} + 5'd1) >= {1'b0, dot_size};
        row_end = ({1'b0, dot_row_reg} + 5'd1) >= {1'b0, dot_size};
        at_last = major_pos_reg >= major_last_reg;
        err_sub = walk_error_reg - $signed({1'b0, delta_minor_reg});
        err_fix = err_sub + $signed({1'b0, delta_major_reg});
        cx      = is_steep_reg ? minor_pos_reg : major_pos_reg;
        cy      = is_steep_reg ? major_pos_reg : minor_pos_reg;
    end

    // Pixel of the current dot, centred on the line point.
    always_comb begin
        pix.valid = item_accept && (op == ytlp_pkg::OP_ADVANCE) && busy_reg && size_ok;
        pix.px    = $signed({1'b0, cx}) - $signed({11'd0, dot_size[3:1]})
                    + $signed({10'd0, dot_col_reg});
        pix.py    = $signed({1'b0, cy}) - $signed({11'd0, dot_size[3:1]})
                    + $signed({10'd0, dot_row_reg});
        pix.last  = col_end && row_end && at_last;
    end

    // Walk state update, one step per accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_last_reg  <= '0;
            walk_error_reg  <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            is_steep_reg    <= 1'b0;
            minor_dec_reg   <= 1'b0;
            dot_col_reg     <= '0;
            dot_row_reg     <= '0;
        end else if (item_accept) begin
            if (op == ytlp_pkg::OP_START) begin
                if (size_ok) begin
                    busy_reg        <= 1'b1;
                    is_steep_reg    <= steep;
                    major_pos_reg   <= a0;
                    major_last_reg  <= a1;
                    minor_pos_reg   <= b0;
                    delta_major_reg <= a1 - a0;
                    delta_minor_reg <= ytlp_pkg::abs_diff(b1, b0);
                    walk_error_reg  <= $signed({1'b0, (a1 - a0) >> 1});
                    minor_dec_reg   <= b0 > b1;
                    dot_col_reg     <= '0;
                    dot_row_reg     <= '0;
                end else begin
                    busy_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (!size_ok) begin
                    busy_reg <= 1'b0;
                end else if (!col_end) begin
                    dot_col_reg <= dot_col_reg + 4'd1;
                end else begin
                    dot_col_reg <= '0;
                    if (!row_end) begin
                        dot_row_reg <= dot_row_reg + 4'd1;
                    end else begin
                        dot_row_reg <= '0;
                        if (at_last) begin
                            busy_reg <= 1'b0;
                        end else begin
                            // Step the major axis; the minor axis moves on error underflow.
                            major_pos_reg <= major_pos_reg + 13'd1;
                            if (err_sub < 0) begin
                                walk_error_reg <= err_fix;
                                minor_pos_reg  <= minor_dec_reg ? minor_pos_reg - 13'd1
                                                                : minor_pos_reg + 13'd1;
                            end else begin
                                walk_error_reg <= err_sub;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/yuyv_thick_line_plotter_top.sv =====
// Top level of the YUYV thick line plotter: configuration, pipeline and clipping.
//
// Usage: configure the frame size, dot size and YUV colour through the write
// port while the block is idle. A start beat (tuser 0) carries both endpoints
// in tdata and produces no output. Each advance beat (tuser 1) produces one
// pixel of the square dot around the current line point; tlast marks the
// final pixel of the line. Advance beats while no line is active, or with an
// invalid dot size, produce nothing.
// The pixel stage loads at the edge that takes the beat, and the output register
// loads from it once the output can take a pixel; m_tvalid comes from that register.
// Throughput: one beat per cycle while the receiver keeps up; the walk update
// feeds a two-register pipeline (pixel stage, then output register after the address multiply).
// When the receiver stalls, the output holds and the pixel stage keeps taking
// beats until it holds a pixel of its own; then s_tready falls. Reset (aresetn
// low, synchronous) restores the default registers, empties the pipeline and
// ends any line.
module yuyv_thick_line_plotter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_start, y_start, x_end, y_end
    input  logic        s_tuser,   // op
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // byte_addr, pixel_x, pixel_y, luma, chroma_u, chroma_v, pad
    output logic [1:0]  m_tuser,   // write_enable, write_chroma
    output logic        m_tlast,   // last_of_line
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [3:0]  dot_size_reg;
    logic [7:0]  luma_reg;
    logic [7:0]  chroma_u_reg;
    logic [7:0]  chroma_v_reg;

    logic                  out_en, st1_en, in_beat;
    ytlp_pkg::ytlp_pixel_t pix;

    logic                  st1_valid_reg;
    logic signed [13:0]    st1_px_reg, st1_py_reg;
    logic                  st1_last_reg;

    logic                  in_frame;
    logic [24:0]           prod;
    logic [24:0]           lin;

    logic                  m_valid_reg;
    logic [24:0]           addr_reg;
    logic [11:0]           pixel_x_reg, pixel_y_reg;
    logic                  we_reg, wc_reg, last_reg;
    logic [7:0]            luma_out_reg, cu_out_reg, cv_out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ytlp_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= ytlp_pkg::RST_FRAME_HEIGHT;
            dot_size_reg     <= ytlp_pkg::RST_DOT_SIZE;
            luma_reg         <= ytlp_pkg::RST_LUMA;
            chroma_u_reg     <= ytlp_pkg::RST_CHROMA;
            chroma_v_reg     <= ytlp_pkg::RST_CHROMA;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ytlp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                ytlp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                ytlp_pkg::REG_DOT_SIZE:     dot_size_reg     <= cfg_wdata[3:0];
                ytlp_pkg::REG_LUMA:         luma_reg         <= cfg_wdata[7:0];
                ytlp_pkg::REG_CHROMA_U:     chroma_u_reg     <= cfg_wdata[7:0];
                ytlp_pkg::REG_CHROMA_V:     chroma_v_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: each stage moves when the one after it can take it.
    assign out_en   = !m_valid_reg || m_tready;
    assign st1_en   = !st1_valid_reg || out_en;
    assign s_tready = st1_en;
    assign in_beat  = s_tvalid && st1_en;

    ytlp_walk u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (in_beat),
        .op           (s_tuser),
        .x_start      (s_tdata[11:0]),
        .y_start      (s_tdata[23:12]),
        .x_end        (s_tdata[35:24]),
        .y_end        (s_tdata[47:36]),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .dot_size     (dot_size_reg),
        .pix          (pix)
    );

    // Pixel stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_en) begin
            st1_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_en) begin
            st1_px_reg   <= pix.px;
            st1_py_reg   <= pix.py;
            st1_last_reg <= pix.last;
        end
    end

    // Clipping against the frame and the luma byte offset.
    always_comb begin
        in_frame = !st1_px_reg[13] && !st1_py_reg[13] && !st1_px_reg[12] && !st1_py_reg[12]
                   && (st1_px_reg[12:0] < frame_width_reg)
                   && (st1_py_reg[12:0] < frame_height_reg);
        prod     = {12'd0, frame_width_reg} * {13'd0, st1_py_reg[11:0]};
        lin      = prod + {13'd0, st1_px_reg[11:0]};
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            addr_reg     <= in_frame ? {lin[23:0], 1'b0} : 25'd0;
            pixel_x_reg  <= in_frame ? st1_px_reg[11:0] : 12'd0;
            pixel_y_reg  <= in_frame ? st1_py_reg[11:0] : 12'd0;
            we_reg       <= in_frame;
            wc_reg       <= in_frame && !st1_px_reg[0];
            last_reg     <= st1_last_reg;
            luma_out_reg <= luma_reg;
            cu_out_reg   <= chroma_u_reg;
            cv_out_reg   <= chroma_v_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, cv_out_reg, cu_out_reg, luma_out_reg,
                       pixel_y_reg, pixel_x_reg, addr_reg};
    assign m_tuser  = {wc_reg, we_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== tb/ytlp_checker.sv =====
// Checker for the thick line plotter: follows the line walk and compares every pixel write.
module ytlp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // x_start, y_start, x_end, y_end
    input  logic        s_tuser,    // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,    // byte_addr, pixel_x, pixel_y, luma, chroma_u, chroma_v, pad
    input  logic [1:0]  m_tuser,    // write_enable, write_chroma
    input  logic        m_tlast,    // last_of_line
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    output int          mismatches,
    output int          writes_owed
);

    // One pixel write as it should leave the block.
    typedef struct {
        logic [24:0] byte_addr;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        write_enable;
        logic        write_chroma;
        logic [7:0]  luma;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
        logic        last_of_line;
    } pixel_write_t;

    pixel_write_t due_writes[$];

    // Shadow of the configuration registers.
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [3:0]  dot_side;
    logic [7:0]  luma_reg;
    logic [7:0]  cu_reg;
    logic [7:0]  cv_reg;

    // Walk state.
    logic               busy;
    logic               steep;
    logic               minor_down;
    logic [12:0]        major_pos;
    logic [12:0]        minor_pos;
    logic [12:0]        major_end;
    logic [12:0]        delta_major;
    logic [12:0]        delta_minor;
    logic signed [13:0] walk_err;
    logic [3:0]         dot_col;
    logic [3:0]         dot_row;

    // Limit a coordinate to the last column or row of the frame.
    function automatic logic [12:0] fit_coord(input logic [11:0] c, input logic [12:0] dim);
        if (dim == 13'd0)
            return 13'd0;
        if ({1'b0, c} >= dim)
            return dim - 13'd1;
        return {1'b0, c};
    endfunction

    function automatic logic dot_drawable();
        return (dot_side != 4'd0) && (dot_side <= ytlp_pkg::MAX_DOT);
    endfunction

    // Apply one input beat to the walk and queue the pixel write it causes, if any.
    task automatic plot_beat(input logic op, input logic [47:0] d);
        logic [12:0]  x0, y0, x1, y1, a0, a1, b0, b1;
        int           dx, dy, px, py, half;
        logic         in_frame;
        logic         fin;
        logic [63:0]  addr;
        pixel_write_t w;
        if (op == ytlp_pkg::OP_START) begin
            x0 = fit_coord(d[11:0], frame_w);
            y0 = fit_coord(d[23:12], frame_h);
            x1 = fit_coord(d[35:24], frame_w);
            y1 = fit_coord(d[47:36], frame_h);
            if (!dot_drawable()) begin
                busy = 1'b0;
                return;
            end
            dx = int'(x1) - int'(x0);
            dy = int'(y1) - int'(y0);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            steep = dy > dx;
            if (steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            // Always walk from the lower major coordinate upward.
            if (a0 > a1) begin
                {a0, a1} = {a1, a0};
                {b0, b1} = {b1, b0};
            end
            major_pos   = a0;
            major_end   = a1;
            minor_pos   = b0;
            delta_major = a1 - a0;
            delta_minor = (b1 > b0) ? b1 - b0 : b0 - b1;
            walk_err    = $signed({1'b0, delta_major >> 1});
            minor_down  = b0 > b1;
            dot_col     = 4'd0;
            dot_row     = 4'd0;
            busy        = 1'b1;
            return;
        end

        if (!busy)
            return;
        if (!dot_drawable()) begin
            busy = 1'b0;
            return;
        end

        half = int'(dot_side >> 1);
        px = int'(steep ? minor_pos : major_pos) - half + int'(dot_col);
        py = int'(steep ? major_pos : minor_pos) - half + int'(dot_row);
        in_frame = px >= 0 && py >= 0 && px <= 4095 && py <= 4095 &&
                   px < int'(frame_w) && py < int'(frame_h);
        fin = 1'b0;

        // Columns first, then rows, then one step of the walk.
        if ({1'b0, dot_col} + 5'd1 < {1'b0, dot_side}) begin
            dot_col = dot_col + 4'd1;
        end else begin
            dot_col = 4'd0;
            if ({1'b0, dot_row} + 5'd1 < {1'b0, dot_side}) begin
                dot_row = dot_row + 4'd1;
            end else begin
                dot_row = 4'd0;
                if (major_pos >= major_end) begin
                    busy = 1'b0;
                    fin  = 1'b1;
                end else begin
                    walk_err = walk_err - $signed({1'b0, delta_minor});
                    if (walk_err < 0) begin
                        minor_pos = minor_down ? minor_pos - 13'd1 : minor_pos + 13'd1;
                        walk_err  = walk_err + $signed({1'b0, delta_major});
                    end
                    major_pos = major_pos + 13'd1;
                end
            end
        end

        if (in_frame) begin
            addr = 2 * (longint'(frame_w) * longint'(py) + longint'(px));
            w.byte_addr    = addr[24:0];
            w.pixel_x      = px[11:0];
            w.pixel_y      = py[11:0];
            w.write_enable = 1'b1;
            w.write_chroma = ~px[0];
        end else begin
            w.byte_addr    = '0;
            w.pixel_x      = '0;
            w.pixel_y      = '0;
            w.write_enable = 1'b0;
            w.write_chroma = 1'b0;
        end
        w.luma         = luma_reg;
        w.chroma_u     = cu_reg;
        w.chroma_v     = cv_reg;
        w.last_of_line = fin;
        due_writes.push_back(w);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Configuration writes, input beats and result beats, all taken at the rising edge.
    always @(posedge aclk) begin : watch
        pixel_write_t w;
        if (!aresetn) begin
            frame_w     = ytlp_pkg::RST_FRAME_WIDTH;
            frame_h     = ytlp_pkg::RST_FRAME_HEIGHT;
            dot_side    = ytlp_pkg::RST_DOT_SIZE;
            luma_reg    = ytlp_pkg::RST_LUMA;
            cu_reg      = ytlp_pkg::RST_CHROMA;
            cv_reg      = ytlp_pkg::RST_CHROMA;
            busy        = 1'b0;
            steep       = 1'b0;
            minor_down  = 1'b0;
            major_pos   = '0;
            minor_pos   = '0;
            major_end   = '0;
            delta_major = '0;
            delta_minor = '0;
            walk_err    = '0;
            dot_col     = '0;
            dot_row     = '0;
            mismatches  = 0;
            due_writes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ytlp_pkg::REG_FRAME_WIDTH:  frame_w  = cfg_wdata;
                    ytlp_pkg::REG_FRAME_HEIGHT: frame_h  = cfg_wdata;
                    ytlp_pkg::REG_DOT_SIZE:     dot_side = cfg_wdata[3:0];
                    ytlp_pkg::REG_LUMA:         luma_reg = cfg_wdata[7:0];
                    ytlp_pkg::REG_CHROMA_U:     cu_reg   = cfg_wdata[7:0];
                    ytlp_pkg::REG_CHROMA_V:     cv_reg   = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                plot_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (due_writes.size() == 0) begin
                    $error("result beat with nothing expected: byte_addr %0d", m_tdata[24:0]);
                    mismatches++;
                end else begin
                    w = due_writes.pop_front();
                    check_field("byte_addr", w.byte_addr, m_tdata[24:0]);
                    check_field("pixel_x", w.pixel_x, m_tdata[36:25]);
                    check_field("pixel_y", w.pixel_y, m_tdata[48:37]);
                    check_field("luma", w.luma, m_tdata[56:49]);
                    check_field("chroma_u", w.chroma_u, m_tdata[64:57]);
                    check_field("chroma_v", w.chroma_v, m_tdata[72:65]);
                    check_field("write_enable", w.write_enable, m_tuser[0]);
                    check_field("write_chroma", w.write_chroma, m_tuser[1]);
                    check_field("last_of_line", w.last_of_line, m_tlast);
                end
            end
        end
        writes_owed <= due_writes.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the thick line plotter: clock, reset, stimulus and verdict.
module tb;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;    // x_start, y_start, x_end, y_end
    logic        s_tuser   = ytlp_pkg::OP_START;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;           // byte_addr, pixel_x, pixel_y, luma, chroma_u, chroma_v, pad
    logic [1:0]  m_tuser;           // write_enable, write_chroma
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = ytlp_pkg::REG_FRAME_WIDTH;
    logic [12:0] cfg_wdata = '0;

    int          mismatches;
    int          writes_owed;
    bit          full_speed = 1'b0;
    int          ready_run  = 0;
    logic [12:0] reg_shadow [0:5];

    yuyv_thick_line_plotter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ytlp_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .writes_owed (writes_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

    // Pause length: mostly short, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver side: ready in runs of random length, broken by stalls.
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else if (full_speed || $urandom_range(0, 9) < 6) begin
            m_tready  <= 1'b1;
            ready_run <= $urandom_range(0, 12);
        end else begin
            m_tready  <= 1'b0;
            ready_run <= pause_len() - 1;
        end
    end

    function automatic logic [47:0] endpoints(input logic [11:0] x0, input logic [11:0] y0,
                                              input logic [11:0] x1, input logic [11:0] y1);
        return {y1, x1, y0, x0};
    endfunction

    function automatic logic [12:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 13'd0;
        if (r == 1) return 13'd1;
        if (r == 2) return 13'd4096;
        if (r == 3) return 13'd8191;
        if (r < 10) return 13'($urandom_range(1, 64));
        return 13'($urandom_range(1, 4096));
    endfunction

    // Endpoint coordinate: often near the frame, sometimes anywhere in 12 bits.
    function automatic logic [11:0] rand_coord(input logic [12:0] dim);
        int hi;
        hi = int'(dim) + 3;
        if (hi > 4095) hi = 4095;
        if ($urandom_range(0, 2) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, hi));
    endfunction

    function automatic logic [11:0] near_coord(input logic [11:0] c);
        int v;
        int off;
        off = $urandom_range(0, 24);
        v = int'(c) + off - 12;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    // Coordinate as the block sees it after fitting to the frame, for sizing a line.
    function automatic int on_frame(input logic [11:0] c, input logic [12:0] dim);
        if (dim == 13'd0) return 0;
        return (int'(c) >= int'(dim)) ? int'(dim) - 1 : int'(c);
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic op, input logic [47:0] d);
        int gap;
        gap = (full_speed || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait until every pixel write has arrived and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (writes_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all six registers from the shadow copy while the block is idle.
    task automatic write_config();
        wait_idle();
        for (int i = int'(ytlp_pkg::REG_FRAME_WIDTH); i <= int'(ytlp_pkg::REG_CHROMA_V); i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= i[2:0];
            cfg_wdata <= reg_shadow[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [11:0] x0, y0, x1, y1;
        int          sent, lines, n, mode, side, ax, ay, pick;
        reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]  = ytlp_pkg::RST_FRAME_WIDTH;
        reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT] = ytlp_pkg::RST_FRAME_HEIGHT;
        reg_shadow[ytlp_pkg::REG_DOT_SIZE]     = 13'(ytlp_pkg::RST_DOT_SIZE);
        reg_shadow[ytlp_pkg::REG_LUMA]         = 13'(ytlp_pkg::RST_LUMA);
        reg_shadow[ytlp_pkg::REG_CHROMA_U]     = 13'(ytlp_pkg::RST_CHROMA);
        reg_shadow[ytlp_pkg::REG_CHROMA_V]     = 13'(ytlp_pkg::RST_CHROMA);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: advance with no line, then a shallow line on reset defaults
        // followed by one advance past its end.
        send_beat(ytlp_pkg::OP_ADVANCE, '0);
        send_beat(ytlp_pkg::OP_START, endpoints(12'd0, 12'd0, 12'd3, 12'd1));
        repeat (4) send_beat(ytlp_pkg::OP_ADVANCE, '1);
        send_beat(ytlp_pkg::OP_ADVANCE, '0);

        // Steep line given bottom to top, minor axis stepping down.
        send_beat(ytlp_pkg::OP_START, endpoints(12'd1, 12'd5, 12'd2, 12'd0));
        repeat (6) send_beat(ytlp_pkg::OP_ADVANCE, '0);

        // A 3x3 dot on the far corner of a full-size frame, extreme colors.
        reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]  = 13'd4096;
        reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT] = 13'd4096;
        reg_shadow[ytlp_pkg::REG_DOT_SIZE]     = 13'd3;
        reg_shadow[ytlp_pkg::REG_LUMA]         = 13'd255;
        reg_shadow[ytlp_pkg::REG_CHROMA_U]     = 13'd0;
        reg_shadow[ytlp_pkg::REG_CHROMA_V]     = 13'd255;
        write_config();
        send_beat(ytlp_pkg::OP_START, endpoints(12'd4095, 12'd4095, 12'd4095, 12'd4095));
        repeat (9) send_beat(ytlp_pkg::OP_ADVANCE, '1);

        // Random lines, mostly complete, some cut short, overrun or resized midway.
        sent  = 0;
        lines = 0;
        while (sent < 750) begin
            if (lines % 6 == 0) begin
                reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]  = pick_dim();
                reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT] = pick_dim();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    reg_shadow[ytlp_pkg::REG_DOT_SIZE] = 13'($urandom_range(0, 15));
                else if (pick == 1)
                    reg_shadow[ytlp_pkg::REG_DOT_SIZE] = 13'(ytlp_pkg::MAX_DOT);
                else
                    reg_shadow[ytlp_pkg::REG_DOT_SIZE] = 13'($urandom_range(1, 4));
                reg_shadow[ytlp_pkg::REG_LUMA]     = 13'($urandom_range(0, 255));
                reg_shadow[ytlp_pkg::REG_CHROMA_U] = 13'($urandom_range(0, 255));
                reg_shadow[ytlp_pkg::REG_CHROMA_V] = 13'($urandom_range(0, 255));
                write_config();
            end
            lines++;
            full_speed <= ($urandom_range(0, 4) == 0);

            x0 = rand_coord(reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]);
            y0 = rand_coord(reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT]);
            if ($urandom_range(0, 9) < 7) begin
                x1 = near_coord(x0);
                y1 = near_coord(y0);
            end else begin
                x1 = 12'($urandom_range(0, 4095));
                y1 = 12'($urandom_range(0, 4095));
            end
            send_beat(ytlp_pkg::OP_START, endpoints(x0, y0, x1, y1));
            sent++;

            // Number of advances that finishes the line exactly.
            side = int'(reg_shadow[ytlp_pkg::REG_DOT_SIZE][3:0]);
            if (side == 0 || side > int'(ytlp_pkg::MAX_DOT)) begin
                n = $urandom_range(0, 3);
            end else begin
                ax = on_frame(x1, reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]) -
                     on_frame(x0, reg_shadow[ytlp_pkg::REG_FRAME_WIDTH]);
                ay = on_frame(y1, reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT]) -
                     on_frame(y0, reg_shadow[ytlp_pkg::REG_FRAME_HEIGHT]);
                if (ax < 0) ax = -ax;
                if (ay < 0) ay = -ay;
                n = ((ax > ay) ? ax : ay) + 1;
                n = n * side * side;
            end

            mode = $urandom_range(0, 9);
            if (mode == 6)
                n = n + $urandom_range(1, 3);
            if (n > 150)
                n = $urandom_range(10, 80);
            else if (mode == 7 && n > 1)
                n = $urandom_range(1, n - 1);

            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && mode == 8) begin
                    // Change the dot size in the middle of a line.
                    reg_shadow[ytlp_pkg::REG_DOT_SIZE] = 13'($urandom_range(0, 15));
                    write_config();
                end else if (k == n / 2 && mode == 9) begin
                    wait_idle();
                end
                send_beat(ytlp_pkg::OP_ADVANCE, {16'($urandom()), $urandom()});
                sent++;
            end
        end

        // Drain and give the verdict.
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && writes_owed == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
